### hdl/hpbd_pkg.sv
// ============================================================================
// hpbd_pkg: shared types and constants for the hash prefix bucket distributor
// Default sizes, field widths, command codes and the result record that the
// back end hands to the top level.
// ============================================================================
package hpbd_pkg;

    localparam int BUCKETS_DEF = 1024;
    localparam int SLOTS_DEF   = 256;

    localparam int CFG_W        = 3;
    localparam int HASH_W       = 32;
    localparam int BUCKET_OUT_W = 10;
    localparam int SLOT_OUT_W   = 8;
    localparam int ADDR_OUT_W   = 18;

    // prefix (32 bits) times bucket count (up to 17 bits)
    localparam int PROD_W = 49;

    localparam logic [CFG_W-1:0] PREFIX_BYTES_RST = 3'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic [BUCKET_OUT_W-1:0] bucket_id;
        logic [SLOT_OUT_W-1:0]   slot_index;
        logic [ADDR_OUT_W-1:0]   write_address;
        logic                    stored;
    } result_t;

endpackage

### hdl/hpbd_front.sv
// ============================================================================
// hpbd_front: front end of the bucket distributor
// Capture one command, cut the hash prefix, scale it to a bucket and push the
// classified beat into the queue.
// ============================================================================
module hpbd_front #(
    parameter int BUCKETS = hpbd_pkg::BUCKETS_DEF,
    parameter int AW      = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         command,
    input  logic [hpbd_pkg::HASH_W-1:0]  hash_head,
    input  logic [hpbd_pkg::CFG_W-1:0]   prefix_bytes,
    input  logic                         q_full,
    output logic                         push,
    output logic                         push_cmd,
    output logic [AW-1:0]                push_bucket,
    output logic                         front_busy
);

    logic                        valid_reg, valid_next;
    logic                        cmd_reg;
    logic [hpbd_pkg::HASH_W-1:0] prefix_reg, prefix_next;
    logic [1:0]                  pbc_reg, pbc_next;

    logic [hpbd_pkg::PROD_W-1:0] prod;
    logic [hpbd_pkg::PROD_W-1:0] shifted;

    // Saturate the byte count to 1..4, held as count minus one
    always_comb
    begin
        case (prefix_bytes) inside
            3'd0, 3'd1: pbc_next = 2'd0;
            3'd2:       pbc_next = 2'd1;
            3'd3:       pbc_next = 2'd2;
            default:    pbc_next = 2'd3;
        endcase
    end

    always_comb
    begin
        case (pbc_next)
            2'd0:    prefix_next = hash_head >> 24;
            2'd1:    prefix_next = hash_head >> 16;
            2'd2:    prefix_next = hash_head >> 8;
            default: prefix_next = hash_head;
        endcase
    end

    always_comb
    begin
        prod = hpbd_pkg::PROD_W'(prefix_reg) * hpbd_pkg::PROD_W'(BUCKETS);
        case (pbc_reg)
            2'd0:    shifted = prod >> 8;
            2'd1:    shifted = prod >> 16;
            2'd2:    shifted = prod >> 24;
            default: shifted = prod >> 32;
        endcase
        if (shifted >= hpbd_pkg::PROD_W'(BUCKETS - 1))
            push_bucket = AW'(BUCKETS - 1);
        else
            push_bucket = AW'(shifted);
    end

    assign push       = valid_reg && !q_full;
    assign push_cmd   = cmd_reg;
    assign front_busy = valid_reg;

    // Hold the beat until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (push)
            valid_next = 1'b0;
        if (accept)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            prefix_reg <= prefix_next;
            pbc_reg    <= pbc_next;
        end
    end

endmodule

### hdl/hpbd_queue.sv
// ============================================================================
// hpbd_queue: two-entry queue between front and back
// Decouple the classifier from the fill-count update.
// ============================================================================
module hpbd_queue #(
    parameter int W = 11
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         full,
    output logic         empty
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### hdl/hpbd_back.sv
// ============================================================================
// hpbd_back: back end of the bucket distributor
// Own the fill-count memory: sweep it clear, read-modify-write one bucket per
// insert and register the result beat.
// ============================================================================
module hpbd_back #(
    parameter int BUCKETS = hpbd_pkg::BUCKETS_DEF,
    parameter int SLOTS   = hpbd_pkg::SLOTS_DEF,
    parameter int AW      = 10,
    parameter int FW      = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  logic              q_cmd,
    input  logic [AW-1:0]     q_bucket,
    output logic              pop,
    output hpbd_pkg::result_t result,
    output logic              init_busy
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic              init_reg, init_next;
    logic [AW-1:0]     bucket_reg, bucket_next;
    logic [hpbd_pkg::ADDR_OUT_W-1:0] base_reg, base_next;
    logic [FW-1:0]     rd_data_reg;
    hpbd_pkg::result_t result_reg, result_next;

    logic [FW-1:0]     fill_mem [BUCKETS];
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [FW-1:0]     wr_data;
    logic              rd_en;
    logic [31:0]       base_full;

    assign pop       = (state_reg == ST_IDLE) && q_valid;
    assign rd_en     = pop && (q_cmd == hpbd_pkg::CMD_INSERT);
    assign base_full = 32'(q_bucket) * 32'(SLOTS);
    assign result    = result_reg;
    assign init_busy = init_reg;

    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        init_next   = init_reg;
        bucket_next = bucket_reg;
        base_next   = base_reg;
        wr_en       = 1'b0;
        wr_addr     = sweep_reg;
        wr_data     = '0;
        result_next = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (sweep_reg == AW'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                end
                else
                    sweep_next = sweep_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (q_cmd == hpbd_pkg::CMD_CLEAR)
                    begin
                        // Report the clear now, then sweep
                        result_next.valid = 1'b1;
                        sweep_next        = '0;
                        state_next        = ST_CLEAR;
                    end
                    else
                    begin
                        bucket_next = q_bucket;
                        base_next   = hpbd_pkg::ADDR_OUT_W'(base_full);
                        state_next  = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                result_next.valid     = 1'b1;
                result_next.bucket_id = hpbd_pkg::BUCKET_OUT_W'(bucket_reg);
                if (rd_data_reg < FW'(SLOTS))
                begin
                    // Take the next slot and advance the fill count
                    wr_en                     = 1'b1;
                    wr_addr                   = bucket_reg;
                    wr_data                   = rd_data_reg + FW'(1);
                    result_next.slot_index    = hpbd_pkg::SLOT_OUT_W'(rd_data_reg);
                    result_next.write_address = base_reg
                                              + hpbd_pkg::ADDR_OUT_W'(rd_data_reg);
                    result_next.stored        = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            sweep_reg  <= '0;
            init_reg   <= 1'b1;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            init_reg   <= init_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bucket_reg <= bucket_next;
        base_reg   <= base_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            fill_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= fill_mem[q_bucket];
    end

endmodule

### hdl/hash_prefix_bucket_distributor_core.sv
// ============================================================================
// hash_prefix_bucket_distributor_core: hash prefix bucket distributor
// Map each record hash to a bucket, hand out the next free slot and a flat
// write address, and clear all fill counts on command.
// ============================================================================
// Pulse start with command and hash_head while busy is low; that cycle takes
// the beat. Every command returns exactly one result beat, shown for one
// cycle with done high; the receiver cannot stall it, so sample it then.
// An insert passes the front register, the queue entry and the back end's
// read and update states before done rises; busy stays high after each
// accepted beat until the queue takes it, and the back end takes a new insert
// only after it has read, then written and reported, the fill count of the
// last one. A clear reports its zero result first and then sweeps the fill
// memory one bucket per cycle; inserts queued behind it wait for the sweep.
// After reset the same sweep runs with busy held high. A full bucket drops
// the record: bucket_id still names the bucket and stored is low.
// Write prefix_bytes (cfg_we, cfg_wdata) only while the block is idle.
// ============================================================================
module hash_prefix_bucket_distributor_core #(
    parameter int BUCKETS = hpbd_pkg::BUCKETS_DEF,
    parameter int SLOTS   = hpbd_pkg::SLOTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hpbd_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic [hpbd_pkg::HASH_W-1:0]        hash_head,
    output logic                               done,
    output logic [hpbd_pkg::BUCKET_OUT_W-1:0]  bucket_id,
    output logic [hpbd_pkg::SLOT_OUT_W-1:0]    slot_index,
    output logic [hpbd_pkg::ADDR_OUT_W-1:0]    write_address,
    output logic                               stored
);

    // bucket index width and fill count width (fill count reaches SLOTS)
    localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int FW = $clog2(SLOTS + 1);
    localparam int QW = AW + 1;

    logic [hpbd_pkg::CFG_W-1:0] prefix_bytes_reg;

    logic              accept;
    logic              front_busy;
    logic              init_busy;
    logic              push;
    logic              push_cmd;
    logic [AW-1:0]     push_bucket;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    logic [QW-1:0]     q_data;
    hpbd_pkg::result_t result;

    // Hold off new beats while the front holds one or the reset sweep runs
    assign busy   = front_busy || init_busy;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prefix_bytes_reg <= hpbd_pkg::PREFIX_BYTES_RST;
        else if (cfg_we)
            prefix_bytes_reg <= cfg_wdata;
    end

    hpbd_front #(
        .BUCKETS (BUCKETS),
        .AW      (AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command      (command),
        .hash_head    (hash_head),
        .prefix_bytes (prefix_bytes_reg),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd),
        .push_bucket  (push_bucket),
        .front_busy   (front_busy)
    );

    hpbd_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cmd, push_bucket}),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    hpbd_back #(
        .BUCKETS (BUCKETS),
        .SLOTS   (SLOTS),
        .AW      (AW),
        .FW      (FW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_empty),
        .q_cmd     (q_data[QW-1]),
        .q_bucket  (q_data[AW-1:0]),
        .pop       (pop),
        .result    (result),
        .init_busy (init_busy)
    );

    assign done          = result.valid;
    assign bucket_id     = result.bucket_id;
    assign slot_index    = result.slot_index;
    assign write_address = result.write_address;
    assign stored        = result.stored;

endmodule

### hdl/hpbd_checker.sv
// ============================================================================
// hpbd_checker: port-level checks for the bucket distributor
// Watch the command and result ports over time.
// ============================================================================
module hpbd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input logic [hpbd_pkg::SLOT_OUT_W-1:0]    slot_index,
    input logic [hpbd_pkg::ADDR_OUT_W-1:0]    write_address,
    input logic                               stored
);

    // Reset always starts with the clearing sweep
    a_busy_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> busy)
        else $error("busy low right after reset");

    // A taken beat blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after an accepted beat");

    // Only a result beat can report a stored record
    a_stored_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        stored |-> done)
        else $error("stored high outside a result beat");

    // Dropped records and clears carry no slot
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !stored) |-> (slot_index == '0 && write_address == '0))
        else $error("slot or address set on a result without a slot");

endmodule

bind hash_prefix_bucket_distributor_core hpbd_checker u_hpbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .slot_index    (slot_index),
    .write_address (write_address),
    .stored        (stored)
);
